[rtl/montgomery_ntt_engine_core_macros.svh]
// assertion macros used by the engine sequencer
`ifndef MONTGOMERY_NTT_ENGINE_CORE_MACROS_SVH
`define MONTGOMERY_NTT_ENGINE_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MNTT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MNTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/mntt_pkg.sv]
// types, constants and helpers of the ntt engine
package mntt_pkg;

  localparam int unsigned MaxPoints = 256;
  localparam int unsigned AddrW     = $clog2(MaxPoints);
  localparam int unsigned TwAddrW   = AddrW - 1;
  localparam int unsigned LogMax    = AddrW;
  localparam int unsigned WordW     = 32;

  localparam logic [1:0] CmdWrite   = 2'd0;
  localparam logic [1:0] CmdRead    = 2'd1;
  localparam logic [1:0] CmdForward = 2'd2;
  localparam logic [1:0] CmdInverse = 2'd3;

  localparam logic [2:0] RegModulus     = 3'd0;
  localparam logic [2:0] RegNegInverse  = 3'd1;
  localparam logic [2:0] RegRSquared    = 3'd2;
  localparam logic [2:0] RegRoot        = 3'd3;
  localparam logic [2:0] RegInverseRoot = 3'd4;
  localparam logic [2:0] RegSizeInverse = 3'd5;
  localparam logic [2:0] RegLogSize     = 3'd6;

  typedef enum logic [2:0] {
    A_CDATA, A_TDATA, A_RES, A_ROOT, A_IROOT, A_SINV, A_ONE
  } a_sel_e;

  typedef enum logic [2:0] {
    B_R2, B_WM, B_SM, B_ONE, B_CDATA
  } b_sel_e;

  typedef enum logic [2:0] {
    WS_VALUE, WS_RES, WS_SUM, WS_DIFF, WS_CDATA, WS_U
  } wsel_e;

  typedef struct packed {
    logic [WordW-1:0] modulus;
    logic [WordW-1:0] neg_inverse;
    logic [WordW-1:0] r_squared;
    logic [WordW-1:0] root;
    logic [WordW-1:0] inverse_root;
    logic [WordW-1:0] size_inverse;
    logic [3:0]       log_size;
  } cfg_t;

  typedef struct packed {
    logic [AddrW-1:0]   c_raddr;
    logic               c_we;
    logic [AddrW-1:0]   c_waddr;
    wsel_e              c_wsel;
    logic [TwAddrW-1:0] t_raddr;
    logic               t_we;
    logic [TwAddrW-1:0] t_waddr;
    logic               r_start;
    a_sel_e             a_sel;
    b_sel_e             b_sel;
    logic               ld_u;
    logic               ld_wm;
    logic               ld_sm;
    logic               out_ld;
    logic               out_cdata;
    logic               out_st;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic busy;
  } stat_t;

  // log size saturated to the supported range
  function automatic logic [3:0] eff_log(input logic [3:0] ls);
    logic [3:0] l;
    l = ls;
    if (l < 4'd1) l = 4'd1;
    if (l > 4'(LogMax)) l = 4'(LogMax);
    return l;
  endfunction

endpackage

[rtl/mntt_if.sv]
// request and response channel interfaces
interface mntt_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  index;
  logic [31:0] value;
  modport source (output valid, output command, output index, output value, input ready);
  modport sink (input valid, input command, input index, input value, output ready);
endinterface

interface mntt_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        status;
  modport source (output valid, output read_value, output status, input ready);
  modport sink (input valid, input read_value, input status, output ready);
endinterface

[rtl/mntt_redc.sv]
// four-stage montgomery multiply and reduce unit
module mntt_redc (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] q_i,
  input  logic [31:0] ninv_i,
  output logic [31:0] res_o,
  output logic        done_o,
  output logic        busy_o
);

  logic [3:0]  v_q;
  logic [63:0] t_q, t2_q, t3_q, c_q;
  logic [31:0] m_q, res_q;
  logic [63:0] mprod;
  logic [64:0] sum;
  logic [32:0] u;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[2:0], start_i};
    end
  end

  assign mprod = t_q[31:0] * ninv_i;
  assign sum   = {1'b0, t3_q} + {1'b0, c_q};
  assign u     = sum[64:32];

  // the product is delayed twice so that it meets m * q of the same request
  always_ff @(posedge clk_i) begin
    t_q  <= a_i * b_i;
    m_q  <= mprod[31:0];
    c_q  <= m_q * q_i;
    t2_q <= t_q;
    t3_q <= t2_q;
    if (v_q[2]) begin
      res_q <= (u >= {1'b0, q_i}) ? 32'(u - {1'b0, q_i}) : u[31:0];
    end
  end

  assign res_o  = res_q;
  assign done_o = v_q[3];
  assign busy_o = |v_q[2:0];

endmodule

[rtl/mntt_datapath.sv]
// coefficient and twiddle memories, reduce unit and butterfly adders
module mntt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mntt_pkg::cfg_t      cfg_i,
  input  mntt_pkg::cmd_t      cmd_i,
  input  logic [31:0]         value_i,
  output mntt_pkg::stat_t     stat_o,
  output logic [31:0]         read_value_o,
  output logic                status_o
);

  logic [31:0] cmem [mntt_pkg::MaxPoints];
  logic [31:0] tmem [mntt_pkg::MaxPoints/2];
  logic [31:0] cdata_q, tdata_q, u_q, wm_q, sm_q, rv_q;
  logic        st_q;
  logic [31:0] opa, opb, res, wdata, sum_v, diff_v;
  logic [32:0] s33;
  logic [63:0] d64, q64;
  logic        done, busy;

  mntt_redc u_redc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.r_start),
    .a_i    (opa),
    .b_i    (opb),
    .q_i    (cfg_i.modulus),
    .ninv_i (cfg_i.neg_inverse),
    .res_o  (res),
    .done_o (done),
    .busy_o (busy)
  );

  assign stat_o = '{done: done, busy: busy};

  always_comb begin
    unique case (cmd_i.a_sel)
      mntt_pkg::A_CDATA: opa = cdata_q;
      mntt_pkg::A_TDATA: opa = tdata_q;
      mntt_pkg::A_RES:   opa = res;
      mntt_pkg::A_ROOT:  opa = cfg_i.root;
      mntt_pkg::A_IROOT: opa = cfg_i.inverse_root;
      mntt_pkg::A_SINV:  opa = cfg_i.size_inverse;
      mntt_pkg::A_ONE:   opa = 32'd1;
      default:           opa = '0;
    endcase
    unique case (cmd_i.b_sel)
      mntt_pkg::B_R2:    opb = cfg_i.r_squared;
      mntt_pkg::B_WM:    opb = wm_q;
      mntt_pkg::B_SM:    opb = sm_q;
      mntt_pkg::B_ONE:   opb = 32'd1;
      mntt_pkg::B_CDATA: opb = cdata_q;
      default:           opb = '0;
    endcase
  end

  // butterfly sum and difference, difference wraps in 64 bits
  assign q64    = {32'd0, cfg_i.modulus};
  assign s33    = {1'b0, u_q} + {1'b0, res};
  assign sum_v  = (s33 >= {1'b0, cfg_i.modulus}) ? 32'(s33 - {1'b0, cfg_i.modulus})
                                                 : s33[31:0];
  assign d64    = {32'd0, u_q} + q64 - {32'd0, res};
  assign diff_v = (d64 >= q64) ? 32'(d64 - q64) : d64[31:0];

  always_comb begin
    unique case (cmd_i.c_wsel)
      mntt_pkg::WS_VALUE: wdata = value_i;
      mntt_pkg::WS_RES:   wdata = res;
      mntt_pkg::WS_SUM:   wdata = sum_v;
      mntt_pkg::WS_DIFF:  wdata = diff_v;
      mntt_pkg::WS_CDATA: wdata = cdata_q;
      mntt_pkg::WS_U:     wdata = u_q;
      default:            wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.c_we) begin
      cmem[cmd_i.c_waddr] <= wdata;
    end
    cdata_q <= cmem[cmd_i.c_raddr];
    if (cmd_i.t_we) begin
      tmem[cmd_i.t_waddr] <= res;
    end
    tdata_q <= tmem[cmd_i.t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_u)  u_q  <= cdata_q;
    if (cmd_i.ld_wm) wm_q <= res;
    if (cmd_i.ld_sm) sm_q <= res;
    if (cmd_i.out_ld) begin
      rv_q <= cmd_i.out_cdata ? cdata_q : 32'd0;
      st_q <= cmd_i.out_st;
    end
  end

  assign read_value_o = rv_q;
  assign status_o     = st_q;

endmodule

[rtl/mntt_ctrl.sv]
// sequencer for requests and the transform passes
`include "montgomery_ntt_engine_core_macros.svh"

module mntt_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic [1:0]      req_command_i,
  input  logic [7:0]      req_index_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  input  logic [3:0]      log_size_i,
  input  mntt_pkg::stat_t stat_i,
  output mntt_pkg::cmd_t  cmd_o
);

  typedef enum logic [27:0] {
    S_IDLE   = 28'h0000001, S_RD     = 28'h0000002,
    S_WM_GO  = 28'h0000004, S_WM_W   = 28'h0000008,
    S_SM_GO  = 28'h0000010, S_SM_W   = 28'h0000020,
    S_TW0_GO = 28'h0000040, S_TW0_W  = 28'h0000080,
    S_TWI_GO = 28'h0000100, S_TWI_W  = 28'h0000200,
    S_EN_RD  = 28'h0000400, S_EN_GO  = 28'h0000800,
    S_EN_W   = 28'h0001000, S_RV_CHK = 28'h0002000,
    S_RV_LD  = 28'h0004000, S_RV_WA  = 28'h0008000,
    S_RV_WB  = 28'h0010000, S_BF_RD  = 28'h0020000,
    S_BF_LD  = 28'h0040000, S_BF_GO  = 28'h0080000,
    S_BF_W   = 28'h0100000, S_BF_WB  = 28'h0200000,
    S_EX_RD  = 28'h0400000, S_EX_GO  = 28'h0800000,
    S_EX_W   = 28'h1000000, S_EX2_GO = 28'h2000000,
    S_EX2_W  = 28'h4000000, S_DONE   = 28'h8000000
  } state_e;

  state_e      state_q, state_d;
  logic [8:0]  i_q, i_d;
  logic [2:0]  s_q, s_d;
  logic [6:0]  b_q, b_d;
  logic        inv_q, inv_d;
  logic        out_valid_q, out_valid_d;

  logic [3:0]  lg;
  logic [8:0]  n;
  logic [7:0]  half_n;
  logic        acc, in_range, i_last, b_last;
  logic [7:0]  rev8, rev, bx, mask, top, bot;
  logic [6:0]  twidx;
  logic [3:0]  twsh;

  assign lg       = mntt_pkg::eff_log(log_size_i);
  assign n        = 9'd1 << lg;
  assign half_n   = n[8:1];
  assign acc      = req_valid_i && req_ready_o;
  assign in_range = {1'b0, req_index_i} < n;
  assign i_last   = i_q == 9'(n - 9'd1);
  assign b_last   = b_q == 7'(half_n - 8'd1);

  // bit reverse of the counter within lg bits
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      rev8[k] = i_q[7-k];
    end
  end
  assign rev = rev8 >> (4'(mntt_pkg::LogMax) - lg);

  // butterfly addressing for stage s, butterfly b
  assign bx    = {1'b0, b_q};
  assign mask  = (8'd1 << s_q) - 8'd1;
  assign top   = ((bx >> s_q) << (s_q + 3'd1)) | (bx & mask);
  assign bot   = top | (8'd1 << s_q);
  assign twsh  = 4'(lg - 4'd1 - {1'b0, s_q});
  assign twidx = 7'((bx & mask) << twsh);

  assign req_ready_o = (state_q == S_IDLE) && (!out_valid_q || rsp_ready_i);
  assign rsp_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    s_d     = s_q;
    b_d     = b_q;
    inv_d   = inv_q;

    cmd_o           = '0;
    cmd_o.c_raddr   = i_q[7:0];
    cmd_o.c_waddr   = i_q[7:0];
    cmd_o.c_wsel    = mntt_pkg::WS_RES;
    cmd_o.t_raddr   = twidx;
    cmd_o.t_waddr   = i_q[6:0];
    cmd_o.a_sel     = mntt_pkg::A_CDATA;
    cmd_o.b_sel     = mntt_pkg::B_R2;

    unique case (state_q)
      S_IDLE: begin
        cmd_o.c_raddr = req_index_i;
        cmd_o.c_waddr = req_index_i;
        cmd_o.c_wsel  = mntt_pkg::WS_VALUE;
        if (acc) begin
          unique case (req_command_i)
            mntt_pkg::CmdWrite: begin
              cmd_o.c_we   = in_range;
              cmd_o.out_ld = 1'b1;
              cmd_o.out_st = !in_range;
            end
            mntt_pkg::CmdRead: begin
              if (in_range) begin
                state_d = S_RD;
              end else begin
                cmd_o.out_ld = 1'b1;
                cmd_o.out_st = 1'b1;
              end
            end
            default: begin
              inv_d   = req_command_i == mntt_pkg::CmdInverse;
              state_d = S_WM_GO;
            end
          endcase
        end
      end
      S_RD: begin
        cmd_o.out_ld    = 1'b1;
        cmd_o.out_cdata = 1'b1;
        state_d         = S_IDLE;
      end
      S_WM_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.a_sel   = inv_q ? mntt_pkg::A_IROOT : mntt_pkg::A_ROOT;
        state_d       = S_WM_W;
      end
      S_WM_W: begin
        if (stat_i.done) begin
          cmd_o.ld_wm = 1'b1;
          state_d     = S_SM_GO;
        end
      end
      S_SM_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.a_sel   = mntt_pkg::A_SINV;
        state_d       = S_SM_W;
      end
      S_SM_W: begin
        if (stat_i.done) begin
          cmd_o.ld_sm = 1'b1;
          state_d     = S_TW0_GO;
        end
      end
      S_TW0_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.a_sel   = mntt_pkg::A_ONE;
        state_d       = S_TW0_W;
      end
      S_TW0_W: begin
        cmd_o.t_waddr = '0;
        if (stat_i.done) begin
          cmd_o.t_we = 1'b1;
          if (half_n == 8'd1) begin
            i_d     = '0;
            state_d = S_EN_RD;
          end else begin
            i_d     = 9'd1;
            state_d = S_TWI_GO;
          end
        end
      end
      S_TWI_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.a_sel   = mntt_pkg::A_RES;
        cmd_o.b_sel   = mntt_pkg::B_WM;
        state_d       = S_TWI_W;
      end
      S_TWI_W: begin
        if (stat_i.done) begin
          cmd_o.t_we = 1'b1;
          if (i_q == {1'b0, 8'(half_n - 8'd1)}) begin
            i_d     = '0;
            state_d = S_EN_RD;
          end else begin
            i_d     = i_q + 9'd1;
            state_d = S_TWI_GO;
          end
        end
      end
      S_EN_RD: state_d = S_EN_GO;
      S_EN_GO: begin
        cmd_o.r_start = 1'b1;
        state_d       = S_EN_W;
      end
      S_EN_W: begin
        if (stat_i.done) begin
          cmd_o.c_we = 1'b1;
          if (i_last) begin
            i_d     = '0;
            state_d = S_RV_CHK;
          end else begin
            i_d     = i_q + 9'd1;
            state_d = S_EN_RD;
          end
        end
      end
      S_RV_CHK: begin
        if (i_q[7:0] < rev) begin
          state_d = S_RV_LD;
        end else if (i_last) begin
          s_d     = '0;
          b_d     = '0;
          state_d = S_BF_RD;
        end else begin
          i_d = i_q + 9'd1;
        end
      end
      S_RV_LD: begin
        cmd_o.ld_u    = 1'b1;
        cmd_o.c_raddr = rev;
        state_d       = S_RV_WA;
      end
      S_RV_WA: begin
        cmd_o.c_we   = 1'b1;
        cmd_o.c_wsel = mntt_pkg::WS_CDATA;
        state_d      = S_RV_WB;
      end
      S_RV_WB: begin
        cmd_o.c_we    = 1'b1;
        cmd_o.c_waddr = rev;
        cmd_o.c_wsel  = mntt_pkg::WS_U;
        if (i_last) begin
          s_d     = '0;
          b_d     = '0;
          state_d = S_BF_RD;
        end else begin
          i_d     = i_q + 9'd1;
          state_d = S_RV_CHK;
        end
      end
      S_BF_RD: begin
        cmd_o.c_raddr = top;
        state_d       = S_BF_LD;
      end
      S_BF_LD: begin
        cmd_o.ld_u    = 1'b1;
        cmd_o.c_raddr = bot;
        state_d       = S_BF_GO;
      end
      S_BF_GO: begin
        cmd_o.c_raddr = bot;
        cmd_o.r_start = 1'b1;
        cmd_o.a_sel   = mntt_pkg::A_TDATA;
        cmd_o.b_sel   = mntt_pkg::B_CDATA;
        state_d       = S_BF_W;
      end
      S_BF_W: begin
        cmd_o.c_waddr = top;
        cmd_o.c_wsel  = mntt_pkg::WS_SUM;
        if (stat_i.done) begin
          cmd_o.c_we = 1'b1;
          state_d    = S_BF_WB;
        end
      end
      S_BF_WB: begin
        cmd_o.c_we    = 1'b1;
        cmd_o.c_waddr = bot;
        cmd_o.c_wsel  = mntt_pkg::WS_DIFF;
        if (b_last) begin
          b_d = '0;
          if ({1'b0, s_q} == 4'(lg - 4'd1)) begin
            i_d     = '0;
            state_d = S_EX_RD;
          end else begin
            s_d     = s_q + 3'd1;
            state_d = S_BF_RD;
          end
        end else begin
          b_d     = b_q + 7'd1;
          state_d = S_BF_RD;
        end
      end
      S_EX_RD: state_d = S_EX_GO;
      S_EX_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.b_sel   = inv_q ? mntt_pkg::B_SM : mntt_pkg::B_ONE;
        state_d       = S_EX_W;
      end
      S_EX_W, S_EX2_W: begin
        if (stat_i.done) begin
          if (inv_q && state_q == S_EX_W) begin
            state_d = S_EX2_GO;
          end else begin
            cmd_o.c_we = 1'b1;
            if (i_last) begin
              state_d = S_DONE;
            end else begin
              i_d     = i_q + 9'd1;
              state_d = S_EX_RD;
            end
          end
        end
      end
      S_EX2_GO: begin
        cmd_o.r_start = 1'b1;
        cmd_o.a_sel   = mntt_pkg::A_RES;
        cmd_o.b_sel   = mntt_pkg::B_ONE;
        state_d       = S_EX2_W;
      end
      S_DONE: begin
        cmd_o.out_ld = 1'b1;
        state_d      = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && rsp_ready_i) out_valid_d = 1'b0;
    if (cmd_o.out_ld) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      i_q         <= '0;
      s_q         <= '0;
      b_q         <= '0;
      inv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      s_q         <= s_d;
      b_q         <= b_d;
      inv_q       <= inv_d;
      out_valid_q <= out_valid_d;
    end
  end

  `MNTT_ASSERT(a_start_free, !(cmd_o.r_start && stat_i.busy), "reduce unit restarted while busy")
  `MNTT_ASSERT(a_wr_in_range, !cmd_o.c_we || ({1'b0, cmd_o.c_waddr} < n), "store write past size")
  `MNTT_ASSERT_NEXT(a_rd_result, acc && (req_command_i == mntt_pkg::CmdRead) && in_range, cmd_o.out_ld && cmd_o.out_cdata, "read request gave no result")

endmodule

[rtl/montgomery_ntt_engine_core.sv]
// top level of the montgomery ntt engine: register port, sequencer, datapath
//
// channel   dir  signals                          request
// req_i     in   valid ready command index value  one store command
// rsp_o     out  valid ready read_value status    one result per request
// apb       in   psel penable pwrite paddr pwdata register write or read
//
// a write result is valid the cycle after acceptance, an in-range read after S_RD
// a transform holds the sequencer until it is done; its length is set by the
//   reduce unit, started for one multiply at a time, and the single
//   coefficient memory read port
// reset clears the control state; the stores are undefined until written
// a stalled result stays in the output register; a new request is taken as
// soon as that register is being emptied
module montgomery_ntt_engine_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  mntt_req_if.sink          req_i,
  mntt_rsp_if.source        rsp_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  mntt_pkg::cfg_t  cfg_q;
  mntt_pkg::cmd_t  cmd;
  mntt_pkg::stat_t stat;
  logic [2:0]      reg_idx;
  logic            wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus      <= 32'd3329;
      cfg_q.neg_inverse  <= 32'd2488732927;
      cfg_q.r_squared    <= 32'd2988;
      cfg_q.root         <= 32'd17;
      cfg_q.inverse_root <= 32'd1175;
      cfg_q.size_inverse <= 32'd3316;
      cfg_q.log_size     <= 4'd8;
    end else if (wr_en) begin
      unique case (reg_idx)
        mntt_pkg::RegModulus:     cfg_q.modulus      <= pwdata;
        mntt_pkg::RegNegInverse:  cfg_q.neg_inverse  <= pwdata;
        mntt_pkg::RegRSquared:    cfg_q.r_squared    <= pwdata;
        mntt_pkg::RegRoot:        cfg_q.root         <= pwdata;
        mntt_pkg::RegInverseRoot: cfg_q.inverse_root <= pwdata;
        mntt_pkg::RegSizeInverse: cfg_q.size_inverse <= pwdata;
        mntt_pkg::RegLogSize:     cfg_q.log_size     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      mntt_pkg::RegModulus:     prdata = cfg_q.modulus;
      mntt_pkg::RegNegInverse:  prdata = cfg_q.neg_inverse;
      mntt_pkg::RegRSquared:    prdata = cfg_q.r_squared;
      mntt_pkg::RegRoot:        prdata = cfg_q.root;
      mntt_pkg::RegInverseRoot: prdata = cfg_q.inverse_root;
      mntt_pkg::RegSizeInverse: prdata = cfg_q.size_inverse;
      mntt_pkg::RegLogSize:     prdata = {28'd0, cfg_q.log_size};
      default:                  prdata = '0;
    endcase
  end

  mntt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_command_i(req_i.command),
    .req_index_i  (req_i.index),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .log_size_i   (cfg_q.log_size),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  mntt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .value_i     (req_i.value),
    .stat_o      (stat),
    .read_value_o(rsp_o.read_value),
    .status_o    (rsp_o.status)
  );

endmodule
